FILE: rtl/core/hsp_pkg.sv
// shared types, constants and register codes for the hsv skin pixel mask
package hsp_pkg;

   // channel and config widths
   localparam int CHAN_BITS     = 8;
   localparam int HUE_CFG_BITS  = 8;
   localparam int SAT_CFG_BITS  = 10;
   localparam int COL_CFG_BITS  = 10;
   localparam int CFG_DATA_BITS = 10;
   localparam int CFG_IDX_BITS  = 3;
   localparam int COLUMN_BITS_DEF = 10;

   // scale factors of the integer cross-multiplied tests
   localparam int HUE_SCALE   = 255;
   localparam int HUE_SECTORS = 6;
   localparam int SAT_SCALE   = 1000;

   // datapath widths
   localparam int HUE_NUM_BITS  = 12;  // signed hue numerator, -255 .. 1275
   localparam int HUE6_BITS     = 11;  // hue bound times sectors
   localparam int HUE_PROD_BITS = 21;  // signed products of the hue test
   localparam int HUE_BND_BITS  = 19;  // unsigned hue bound products
   localparam int SAT_PROD_BITS = 18;  // products of the saturation test

   // register indexes
   localparam logic [CFG_IDX_BITS-1:0] REG_HUE_LOW      = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_HUE_HIGH     = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_SAT_LOW      = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_SAT_HIGH     = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] REG_COLUMN_START = 3'd4;

   // register reset values
   localparam logic [HUE_CFG_BITS-1:0] HUE_LOW_RST      = 8'd2;
   localparam logic [HUE_CFG_BITS-1:0] HUE_HIGH_RST     = 8'd29;
   localparam logic [SAT_CFG_BITS-1:0] SAT_LOW_RST      = 10'd90;
   localparam logic [SAT_CFG_BITS-1:0] SAT_HIGH_RST     = 10'd700;
   localparam logic [COL_CFG_BITS-1:0] COLUMN_START_RST = 10'd50;

   typedef struct packed {
      logic [HUE_CFG_BITS-1:0] hue_low;
      logic [HUE_CFG_BITS-1:0] hue_high;
      logic [SAT_CFG_BITS-1:0] sat_low;
      logic [SAT_CFG_BITS-1:0] sat_high;
      logic [COL_CFG_BITS-1:0] column_start;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } pixel_type;

   // after the first stage: extremes, hue numerator, scaled hue bounds
   typedef struct packed {
      pixel_type                       pix;
      logic                            pre_ok;
      logic [CHAN_BITS-1:0]            vmax;
      logic [CHAN_BITS-1:0]            delta;
      logic signed [HUE_NUM_BITS-1:0]  hue_num;
      logic [HUE6_BITS-1:0]            hue6_low;
      logic [HUE6_BITS-1:0]            hue6_high;
   } s1_type;

   // after the second stage: all cross products
   typedef struct packed {
      pixel_type                       pix;
      logic                            pre_ok;
      logic signed [HUE_PROD_BITS-1:0] hue_val;
      logic [HUE_BND_BITS-1:0]         hue_lo;
      logic [HUE_BND_BITS-1:0]         hue_hi;
      logic [SAT_PROD_BITS-1:0]        sat_val;
      logic [SAT_PROD_BITS-1:0]        sat_lo;
      logic [SAT_PROD_BITS-1:0]        sat_hi;
   } s2_type;

endpackage

FILE: rtl/core/hsp_csr_regs.sv
// configuration registers of the skin mask
module hsp_csr_regs
   import hsp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CFG_IDX_BITS-1:0]  csr_index,
   input  logic [CFG_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode, unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_HUE_LOW:      cfg_in.hue_low      = csr_wdata[HUE_CFG_BITS-1:0];
            REG_HUE_HIGH:     cfg_in.hue_high     = csr_wdata[HUE_CFG_BITS-1:0];
            REG_SAT_LOW:      cfg_in.sat_low      = csr_wdata[SAT_CFG_BITS-1:0];
            REG_SAT_HIGH:     cfg_in.sat_high     = csr_wdata[SAT_CFG_BITS-1:0];
            REG_COLUMN_START: cfg_in.column_start = csr_wdata[COL_CFG_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_low      <= HUE_LOW_RST;
         cfg_ff.hue_high     <= HUE_HIGH_RST;
         cfg_ff.sat_low      <= SAT_LOW_RST;
         cfg_ff.sat_high     <= SAT_HIGH_RST;
         cfg_ff.column_start <= COLUMN_START_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/hsp_hsv_stage.sv
// first pipeline stage: max, min, delta, hue numerator and column check
module hsp_hsv_stage
   import hsp_pkg::*;
#(
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pixel_type              in_pix,
   input  logic [COLUMN_BITS-1:0] in_column,
   output logic                   out_valid,
   input  logic                   out_ready,
   output s1_type                 out_data
);

   localparam int CMP_BITS = (COLUMN_BITS > COL_CFG_BITS) ? COLUMN_BITS : COL_CFG_BITS;

   logic   vld_ff;
   s1_type data_ff;
   s1_type data_in;

   logic [CHAN_BITS-1:0]           vmax;
   logic [CHAN_BITS-1:0]           vmin;
   logic [CHAN_BITS-1:0]           delta;
   logic signed [HUE_NUM_BITS-1:0] rs;
   logic signed [HUE_NUM_BITS-1:0] gs;
   logic signed [HUE_NUM_BITS-1:0] bs;
   logic signed [HUE_NUM_BITS-1:0] ds;
   logic signed [HUE_NUM_BITS-1:0] hue_num;
   logic                           col_ok;

   // extremes and hue sector, red wins ties, then green
   always_comb begin
      vmax = in_pix.blue;
      vmin = in_pix.blue;
      if (in_pix.red > vmax) vmax = in_pix.red;
      if (in_pix.red < vmin) vmin = in_pix.red;
      if (in_pix.green > vmax) vmax = in_pix.green;
      if (in_pix.green < vmin) vmin = in_pix.green;
      delta = vmax - vmin;
      rs = $signed(HUE_NUM_BITS'(in_pix.red));
      gs = $signed(HUE_NUM_BITS'(in_pix.green));
      bs = $signed(HUE_NUM_BITS'(in_pix.blue));
      ds = $signed(HUE_NUM_BITS'(delta));
      if (in_pix.red == vmax) begin
         hue_num = gs - bs;
      end else if (in_pix.green == vmax) begin
         hue_num = (ds <<< 1) + bs - rs;
      end else begin
         hue_num = (ds <<< 2) + rs - gs;
      end
      col_ok = CMP_BITS'(in_column) >= CMP_BITS'(cfg.column_start);
   end

   // stage payload
   always_comb begin
      data_in.pix       = in_pix;
      data_in.pre_ok    = col_ok && (delta != '0);
      data_in.vmax      = vmax;
      data_in.delta     = delta;
      data_in.hue_num   = hue_num;
      data_in.hue6_low  = HUE6_BITS'(cfg.hue_low) * HUE6_BITS'(HUE_SECTORS);
      data_in.hue6_high = HUE6_BITS'(cfg.hue_high) * HUE6_BITS'(HUE_SECTORS);
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/core/hsp_mult_stage.sv
// second pipeline stage: cross products of the hue and saturation tests
module hsp_mult_stage
   import hsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  s1_type  in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output s2_type  out_data
);

   localparam logic signed [HUE_PROD_BITS-1:0] HUE_K = HUE_PROD_BITS'(HUE_SCALE);
   localparam logic [SAT_PROD_BITS-1:0]        SAT_K = SAT_PROD_BITS'(SAT_SCALE);

   logic   vld_ff;
   s2_type data_ff;
   s2_type data_in;

   // one product per term, each at most 21 bits
   always_comb begin
      data_in.pix     = in_data.pix;
      data_in.pre_ok  = in_data.pre_ok;
      data_in.hue_val = HUE_PROD_BITS'(in_data.hue_num) * HUE_K;
      data_in.hue_lo  = HUE_BND_BITS'(in_data.hue6_low) * HUE_BND_BITS'(in_data.delta);
      data_in.hue_hi  = HUE_BND_BITS'(in_data.hue6_high) * HUE_BND_BITS'(in_data.delta);
      data_in.sat_val = SAT_PROD_BITS'(in_data.delta) * SAT_K;
      data_in.sat_lo  = SAT_PROD_BITS'(cfg.sat_low) * SAT_PROD_BITS'(in_data.vmax);
      data_in.sat_hi  = SAT_PROD_BITS'(cfg.sat_high) * SAT_PROD_BITS'(in_data.vmax);
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/core/hsp_mask_stage.sv
// third pipeline stage: range compares and masked output register
module hsp_mask_stage
   import hsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  s2_type    in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output pixel_type out_pix,
   output logic      out_skin
);

   logic      vld_ff;
   pixel_type pix_ff;
   pixel_type pix_in;
   logic      skin_ff;
   logic      skin_in;
   logic      hue_ok;
   logic      sat_ok;

   // inclusive bounds on both tests, blank the pixel when any fails or the first-stage pre check is false
   always_comb begin
      hue_ok = (in_data.hue_val >= $signed(HUE_PROD_BITS'(in_data.hue_lo))) &&
               (in_data.hue_val <= $signed(HUE_PROD_BITS'(in_data.hue_hi)));
      sat_ok = (in_data.sat_val >= in_data.sat_lo) && (in_data.sat_val <= in_data.sat_hi);
      skin_in = in_data.pre_ok && hue_ok && sat_ok;
      pix_in  = skin_in ? in_data.pix : '0;
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pix_ff  <= pix_in;
         skin_ff <= skin_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_pix   = pix_ff;
   assign out_skin  = skin_ff;

endmodule

FILE: rtl/core/hsv_skin_pixel_mask.sv
// hsv skin pixel mask top level: config registers and three-stage pipeline
// path: an accepted item passes the hsv, mult and mask stage registers in order
// throughput: one item per cycle while the output is not stalled, set by the three-stage pipeline
// back-pressure: each stage holds its item until the next one has room
// reset: clears all stage valid bits and loads the register reset values
// no clearing pass, items are accepted from the first cycle after reset
module hsv_skin_pixel_mask
   import hsp_pkg::*;
#(
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CFG_IDX_BITS-1:0]  csr_index,
   input  logic [CFG_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // red_in[7:0], green_in[15:8], blue_in[23:16], column[24 +: COLUMN_BITS], zero pad
   input  logic [((3*CHAN_BITS+COLUMN_BITS+7)/8)*8-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic [3*CHAN_BITS-1:0]   rsp_tdata,
   // is_skin[0]
   output logic                     rsp_tuser
);

   cfg_type                cfg;
   pixel_type              in_pix;
   logic [COLUMN_BITS-1:0] in_column;
   logic                   s1_valid;
   logic                   s1_ready;
   s1_type                 s1_data;
   logic                   s2_valid;
   logic                   s2_ready;
   s2_type                 s2_data;
   pixel_type              out_pix;

   // unpack the input item
   assign in_pix.red   = req_tdata[CHAN_BITS-1:0];
   assign in_pix.green = req_tdata[2*CHAN_BITS-1:CHAN_BITS];
   assign in_pix.blue  = req_tdata[3*CHAN_BITS-1:2*CHAN_BITS];
   assign in_column    = req_tdata[3*CHAN_BITS +: COLUMN_BITS];

   hsp_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hsp_hsv_stage #(
      .COLUMN_BITS (COLUMN_BITS)
   ) u_hsv (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pix    (in_pix),
      .in_column (in_column),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   hsp_mult_stage u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   hsp_mask_stage u_mask (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pix   (out_pix),
      .out_skin  (rsp_tuser)
   );

   // pack the result item
   assign rsp_tdata = {out_pix.blue, out_pix.green, out_pix.red};

`ifndef ASSERT_OFF
   // the input side only stalls when the whole pipeline is backed up
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while the output stage can move");

   // a blanked item carries black
   a_blank_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("blanked item is not black");

   // a passing pixel is never grey
   a_skin_not_grey: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
      !((rsp_tdata[CHAN_BITS-1:0] == rsp_tdata[2*CHAN_BITS-1:CHAN_BITS]) &&
        (rsp_tdata[CHAN_BITS-1:0] == rsp_tdata[3*CHAN_BITS-1:2*CHAN_BITS])))
      else $error("grey pixel marked as skin");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule
